[rtl/core/aesbcm_pkg.sv]
// Shared types, constants and cipher functions for the AES mode engine.
// Used by aesbcm_ctrl, aesbcm_dp, aes_block_cipher_modes_top and the testbench; no dependencies.
`default_nettype none
package aesbcm_pkg;

    localparam int MAX_RK_WORDS_DEF = 60;

    localparam logic [2:0] ACT_CTR     = 3'd0;
    localparam logic [2:0] ACT_CBC_ENC = 3'd1;
    localparam logic [2:0] ACT_CBC_DEC = 3'd2;
    localparam logic [2:0] ACT_RAW_ENC = 3'd3;
    localparam logic [2:0] ACT_RAW_DEC = 3'd4;

    localparam logic [2:0] REG_KEY0    = 3'd0;
    localparam logic [2:0] REG_KEY1    = 3'd1;
    localparam logic [2:0] REG_KEY2    = 3'd2;
    localparam logic [2:0] REG_KEY3    = 3'd3;
    localparam logic [2:0] REG_KEYSIZE = 3'd4;
    localparam logic [2:0] REG_IV_HIGH = 3'd5;
    localparam logic [2:0] REG_IV_LOW  = 3'd6;

    localparam logic [1:0] KSZ_128    = 2'd0;
    localparam logic [1:0] KSZ_192    = 2'd1;
    localparam logic [1:0] KSZ_256    = 2'd2;
    localparam logic [1:0] KSZ_UNUSED = 2'd3;

    localparam logic [7:0] GF_POLY = 8'h1b;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DISPATCH = 6'b000010,
        ST_EXPAND   = 6'b000100,
        ST_CINIT    = 6'b001000,
        ST_CROUND   = 6'b010000,
        ST_FINISH   = 6'b100000
    } state_t;

    typedef struct packed {
        logic load;
        logic exp_step;
        logic crypt_init;
        logic crypt_round;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic keys_ready;
        logic exp_last;
        logic round_last;
        logic need_crypt;
        logic out_free;
    } sts_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RSBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] byte_of(input logic [127:0] s, input int j);
        return s[127 - 8 * j -: 8];
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] k,
                                               input logic last);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3, x;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[127 - 8 * (4 * c + i) -: 8] = SBOX[byte_of(s, 4 * ((c + i) % 4) + i)];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = byte_of(t, 4 * c);
                a1 = byte_of(t, 4 * c + 1);
                a2 = byte_of(t, 4 * c + 2);
                a3 = byte_of(t, 4 * c + 3);
                x = a0 ^ a1 ^ a2 ^ a3;
                t[127 - 32 * c -: 32] = {a0 ^ x ^ xtime(a0 ^ a1), a1 ^ x ^ xtime(a1 ^ a2),
                                         a2 ^ x ^ xtime(a2 ^ a3), a3 ^ x ^ xtime(a3 ^ a0)};
            end
        end
        return t ^ k;
    endfunction

    function automatic logic [7:0] mul9(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xtime(a);
        a4 = xtime(a2);
        a8 = xtime(a4);
        return a8 ^ a;
    endfunction

    function automatic logic [7:0] mul11(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xtime(a);
        a4 = xtime(a2);
        a8 = xtime(a4);
        return a8 ^ a2 ^ a;
    endfunction

    function automatic logic [7:0] mul13(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xtime(a);
        a4 = xtime(a2);
        a8 = xtime(a4);
        return a8 ^ a4 ^ a;
    endfunction

    function automatic logic [7:0] mul14(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xtime(a);
        a4 = xtime(a2);
        a8 = xtime(a4);
        return a8 ^ a4 ^ a2;
    endfunction

    function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] k,
                                               input logic mix);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[127 - 8 * (4 * ((c + i) % 4) + i) -: 8] = RSBOX[byte_of(s, 4 * c + i)];
            end
        end
        t = t ^ k;
        if (mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = byte_of(t, 4 * c);
                a1 = byte_of(t, 4 * c + 1);
                a2 = byte_of(t, 4 * c + 2);
                a3 = byte_of(t, 4 * c + 3);
                t[127 - 32 * c -: 32] = {
                    mul14(a0) ^ mul11(a1) ^ mul13(a2) ^ mul9(a3),
                    mul9(a0) ^ mul14(a1) ^ mul11(a2) ^ mul13(a3),
                    mul13(a0) ^ mul9(a1) ^ mul14(a2) ^ mul11(a3),
                    mul11(a0) ^ mul13(a1) ^ mul9(a2) ^ mul14(a3)};
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mask_bytes(input logic [127:0] v, input logic [4:0] n);
        logic [127:0] r;
        r = v;
        for (int j = 0; j < 16; j++) begin
            if (5'(j) >= n) begin
                r[127 - 8 * j -: 8] = 8'h00;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/aesbcm_ctrl.sv]
// Sequencing state machine of the AES mode engine.
// Depends on aesbcm_pkg; drives the datapath aesbcm_dp through command and status structs.
`default_nettype none
module aesbcm_ctrl (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    output aesbcm_pkg::cmd_t   cmd,
    input  aesbcm_pkg::sts_t   sts
);

    aesbcm_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            aesbcm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = aesbcm_pkg::ST_DISPATCH;
                end
            end
            aesbcm_pkg::ST_DISPATCH: begin
                priority if (!sts.keys_ready) begin
                    state_next = aesbcm_pkg::ST_EXPAND;
                end else if (sts.need_crypt) begin
                    state_next = aesbcm_pkg::ST_CINIT;
                end else begin
                    state_next = aesbcm_pkg::ST_FINISH;
                end
            end
            aesbcm_pkg::ST_EXPAND: begin
                cmd.exp_step = 1'b1;
                if (sts.exp_last) begin
                    state_next = sts.need_crypt ? aesbcm_pkg::ST_CINIT : aesbcm_pkg::ST_FINISH;
                end
            end
            aesbcm_pkg::ST_CINIT: begin
                cmd.crypt_init = 1'b1;
                state_next     = aesbcm_pkg::ST_CROUND;
            end
            aesbcm_pkg::ST_CROUND: begin
                cmd.crypt_round = 1'b1;
                if (sts.round_last) begin
                    state_next = aesbcm_pkg::ST_FINISH;
                end
            end
            aesbcm_pkg::ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = aesbcm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = aesbcm_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == aesbcm_pkg::ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= aesbcm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == aesbcm_pkg::ST_DISPATCH))
        else $error("Engine did not leave idle after taking an item.");

    a_last_round: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.crypt_round && sts.round_last) |=> (state_reg == aesbcm_pkg::ST_FINISH))
        else $error("Final round did not lead to result delivery.");

    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> s_ready)
        else $error("Engine not ready after delivering a result.");

endmodule
`default_nettype wire

[rtl/core/aesbcm_dp.sv]
// Datapath of the AES mode engine: configuration, key schedule store, round unit, mode state.
// Depends on aesbcm_pkg; controlled by aesbcm_ctrl.
`default_nettype none
module aesbcm_dp #(
    parameter int MAX_ROUND_KEY_WORDS = aesbcm_pkg::MAX_RK_WORDS_DEF
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                cfg_wr_en,
    input  wire  [2:0]         cfg_index,
    input  wire  [63:0]        cfg_wr_data,
    input  wire  [2:0]         s_action,
    input  wire                s_restart,
    input  wire  [4:0]         s_valid_bytes,
    input  wire  [63:0]        s_block_high,
    input  wire  [63:0]        s_block_low,
    output logic               m_valid,
    input  wire                m_ready,
    output logic [63:0]        m_result_high,
    output logic [63:0]        m_result_low,
    output logic               m_status,
    input  aesbcm_pkg::cmd_t   cmd,
    output aesbcm_pkg::sts_t   sts
);

    localparam int ROWS  = MAX_ROUND_KEY_WORDS / 4;
    localparam int ROW_W = $clog2(ROWS);
    localparam int EXP_W = $clog2(MAX_ROUND_KEY_WORDS);
    localparam bit FIT8  = (MAX_ROUND_KEY_WORDS >= 60);
    localparam bit FIT6  = (MAX_ROUND_KEY_WORDS >= 52);

    logic [63:0]  key_reg [4];
    logic [1:0]   ksz_reg;
    logic [127:0] iv_reg;
    logic         keys_ready_reg;
    logic [3:0]   rc_reg;
    logic [3:0]   nk_reg;
    logic [127:0] rk_mem [ROWS];

    logic [EXP_W-1:0] exp_idx_reg;
    logic [2:0]       mod_reg;
    logic [7:0]       rcon_reg;
    logic [31:0]      win_reg [8];

    logic [127:0] st_reg, aux_reg, ctr_reg, chain_reg;
    logic [4:0]   nb_reg;
    logic         enc_reg, need_reg, stat_reg, upd_chain_reg;
    logic [3:0]   rnd_reg;

    logic         m_valid_reg, m_status_reg;
    logic [127:0] m_data_reg;

    logic [3:0]   nk_eff;
    logic [4:0]   n_clamp;
    logic [127:0] din, cur_ctr, cur_chain;
    logic [31:0]  key_word, prev_word, far_word, t_word, new_word;
    logic         in_key;
    logic [3:0]   row_sel;
    logic [127:0] row_key;
    logic         round_last;

    logic [127:0] ld_st, ld_aux, ld_ctr, ld_chain;
    logic [4:0]   ld_nb;
    logic         ld_enc, ld_need, ld_stat, ld_upd;

    always_comb begin
        unique case (ksz_reg)
            aesbcm_pkg::KSZ_128: nk_eff = 4'd4;
            aesbcm_pkg::KSZ_192: nk_eff = FIT6 ? 4'd6 : 4'd4;
            default:             nk_eff = FIT8 ? 4'd8 : (FIT6 ? 4'd6 : 4'd4);
        endcase
    end

    assign n_clamp   = (s_valid_bytes > 5'd16) ? 5'd16 : s_valid_bytes;
    assign din       = {s_block_high, s_block_low};
    assign cur_ctr   = s_restart ? iv_reg : ctr_reg;
    assign cur_chain = s_restart ? iv_reg : chain_reg;

    always_comb begin
        ld_st    = din;
        ld_aux   = '0;
        ld_ctr   = cur_ctr;
        ld_chain = cur_chain;
        ld_nb    = n_clamp;
        ld_enc   = 1'b1;
        ld_need  = 1'b1;
        ld_stat  = 1'b0;
        ld_upd   = 1'b0;
        unique case (s_action)
            aesbcm_pkg::ACT_CTR: begin
                ld_st   = cur_ctr;
                ld_aux  = din;
                ld_need = (n_clamp != 5'd0);
                if (n_clamp != 5'd0) begin
                    ld_ctr = cur_ctr + 128'd1;
                end
            end
            aesbcm_pkg::ACT_CBC_ENC: begin
                ld_st   = din ^ cur_chain;
                ld_need = (n_clamp == 5'd16);
                ld_stat = (n_clamp != 5'd16);
                ld_nb   = (n_clamp == 5'd16) ? 5'd16 : 5'd0;
                ld_upd  = (n_clamp == 5'd16);
            end
            aesbcm_pkg::ACT_CBC_DEC: begin
                ld_aux  = cur_chain;
                ld_enc  = 1'b0;
                ld_need = (n_clamp == 5'd16);
                ld_stat = (n_clamp != 5'd16);
                ld_nb   = (n_clamp == 5'd16) ? 5'd16 : 5'd0;
                if (n_clamp == 5'd16) begin
                    ld_chain = din;
                end
            end
            aesbcm_pkg::ACT_RAW_ENC: ;
            aesbcm_pkg::ACT_RAW_DEC: begin
                ld_enc = 1'b0;
            end
            default: begin
                ld_need = 1'b0;
                ld_nb   = 5'd0;
            end
        endcase
    end

    // Key schedule: one word per cycle, with the last eight words kept in a window.
    assign in_key    = ({{(EXP_W-4){1'b0}}, nk_reg} > exp_idx_reg);
    assign key_word  = exp_idx_reg[0] ? key_reg[exp_idx_reg[2:1]][31:0]
                                      : key_reg[exp_idx_reg[2:1]][63:32];
    assign prev_word = win_reg[0];
    assign far_word  = win_reg[3'(nk_reg - 4'd1)];

    always_comb begin
        priority if (mod_reg == 3'd0) begin
            t_word = aesbcm_pkg::sub_word({prev_word[23:0], prev_word[31:24]}) ^ {rcon_reg, 24'h0};
        end else if (nk_reg == 4'd8 && mod_reg == 3'd4) begin
            t_word = aesbcm_pkg::sub_word(prev_word);
        end else begin
            t_word = prev_word;
        end
    end

    assign new_word = in_key ? key_word : (far_word ^ t_word);

    assign row_sel    = cmd.crypt_init ? (enc_reg ? 4'd0 : rc_reg) : rnd_reg;
    assign row_key    = rk_mem[row_sel[ROW_W-1:0]];
    assign round_last = enc_reg ? (rnd_reg == rc_reg) : (rnd_reg == 4'd0);

    assign sts.keys_ready = keys_ready_reg;
    assign sts.exp_last   = (exp_idx_reg == EXP_W'({rc_reg, 2'b11}));
    assign sts.round_last = round_last;
    assign sts.need_crypt = need_reg;
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.exp_step) begin
            rk_mem[exp_idx_reg[EXP_W-1:2]][(3 - 32'(exp_idx_reg[1:0])) * 32 +: 32] <= new_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                key_reg[i] <= '0;
            end
            ksz_reg        <= '0;
            iv_reg         <= '0;
            keys_ready_reg <= 1'b0;
            rc_reg         <= 4'd10;
            ctr_reg        <= '0;
            chain_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    aesbcm_pkg::REG_KEY0, aesbcm_pkg::REG_KEY1,
                    aesbcm_pkg::REG_KEY2, aesbcm_pkg::REG_KEY3: begin
                        key_reg[cfg_index[1:0]] <= cfg_wr_data;
                        keys_ready_reg          <= 1'b0;
                    end
                    aesbcm_pkg::REG_KEYSIZE: begin
                        ksz_reg        <= cfg_wr_data[1:0];
                        keys_ready_reg <= 1'b0;
                    end
                    aesbcm_pkg::REG_IV_HIGH: iv_reg[127:64] <= cfg_wr_data;
                    aesbcm_pkg::REG_IV_LOW:  iv_reg[63:0]   <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (cmd.load) begin
                ctr_reg   <= ld_ctr;
                chain_reg <= ld_chain;
                if (!keys_ready_reg) begin
                    rc_reg <= nk_eff + 4'd6;
                end
            end
            if (cmd.exp_step && sts.exp_last) begin
                keys_ready_reg <= 1'b1;
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
                if (upd_chain_reg) begin
                    chain_reg <= st_reg;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            nk_reg        <= nk_eff;
            exp_idx_reg   <= '0;
            mod_reg       <= '0;
            rcon_reg      <= 8'h01;
            st_reg        <= ld_st;
            aux_reg       <= ld_aux;
            nb_reg        <= ld_nb;
            enc_reg       <= ld_enc;
            need_reg      <= ld_need;
            stat_reg      <= ld_stat;
            upd_chain_reg <= ld_upd;
        end
        if (cmd.exp_step) begin
            exp_idx_reg <= exp_idx_reg + EXP_W'(1);
            mod_reg     <= (mod_reg == 3'(nk_reg - 4'd1)) ? 3'd0 : mod_reg + 3'd1;
            if (!in_key && mod_reg == 3'd0) begin
                rcon_reg <= aesbcm_pkg::xtime(rcon_reg);
            end
            win_reg[0] <= new_word;
            for (int j = 1; j < 8; j++) begin
                win_reg[j] <= win_reg[j-1];
            end
        end
        if (cmd.crypt_init) begin
            st_reg  <= st_reg ^ row_key;
            rnd_reg <= enc_reg ? 4'd1 : rc_reg - 4'd1;
        end
        if (cmd.crypt_round) begin
            st_reg  <= enc_reg ? aesbcm_pkg::enc_round(st_reg, row_key, round_last)
                               : aesbcm_pkg::dec_round(st_reg, row_key, rnd_reg != 4'd0);
            rnd_reg <= enc_reg ? rnd_reg + 4'd1 : rnd_reg - 4'd1;
        end
        if (cmd.finish) begin
            m_data_reg   <= aesbcm_pkg::mask_bytes((need_reg ? st_reg : 128'd0) ^ aux_reg, nb_reg);
            m_status_reg <= stat_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_high = m_data_reg[127:64];
    assign m_result_low  = m_data_reg[63:0];
    assign m_status      = m_status_reg;

endmodule
`default_nettype wire

[rtl/core/aes_block_cipher_modes_top.sv]
// Top level of the AES engine with CTR, CBC and raw block modes.
// Depends on aesbcm_pkg, aesbcm_ctrl and aesbcm_dp.
//
//  Channel   Handshake             Payload
//  cfg       cfg_wr_en             cfg_index, cfg_wr_data
//  s         s_valid / s_ready     s_action, s_restart, s_valid_bytes, s_block_high/low
//  m         m_valid / m_ready     m_result_high, m_result_low, m_status
//
// An item that needs the cipher passes through the round unit, which does one round per
// cycle; an item that needs none goes straight to result delivery.
// After reset or a key or key-size write, the first item first runs the key schedule at
// one word per cycle. Reset is synchronous and active low.
// One item is in work at a time; a finished item waits in the output register while the
// next is taken, and a stalled output holds the engine before it writes the next result.
`default_nettype none
module aes_block_cipher_modes_top #(
    parameter int MAX_ROUND_KEY_WORDS = aesbcm_pkg::MAX_RK_WORDS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [2:0]  cfg_index,
    input  wire  [63:0] cfg_wr_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [2:0]  s_action,
    input  wire         s_restart,
    input  wire  [4:0]  s_valid_bytes,
    input  wire  [63:0] s_block_high,
    input  wire  [63:0] s_block_low,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [63:0] m_result_high,
    output logic [63:0] m_result_low,
    output logic        m_status
);

    aesbcm_pkg::cmd_t cmd;
    aesbcm_pkg::sts_t sts;

    aesbcm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    aesbcm_dp #(
        .MAX_ROUND_KEY_WORDS (MAX_ROUND_KEY_WORDS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_action      (s_action),
        .s_restart     (s_restart),
        .s_valid_bytes (s_valid_bytes),
        .s_block_high  (s_block_high),
        .s_block_low   (s_block_low),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_high (m_result_high),
        .m_result_low  (m_result_low),
        .m_status      (m_status),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule
`default_nettype wire

[tb/tb_aes_block_cipher_modes_top.sv]
// Self-checking testbench for the AES engine with CTR, CBC and raw block modes.
// Needs aesbcm_pkg and aes_block_cipher_modes_top; predicts every result with its own AES model.
`timescale 1ns / 100ps
`default_nettype none
module tb_aes_block_cipher_modes_top;

    typedef struct {
        logic [2:0]  action;
        logic        restart;
        logic [4:0]  vbytes;
        logic [63:0] hi;
        logic [63:0] lo;
    } block_item_t;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        status;
    } cipher_out_t;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action = '0;
    logic        s_restart = 1'b0;
    logic [4:0]  s_valid_bytes = '0;
    logic [63:0] s_block_high = '0;
    logic [63:0] s_block_low = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_result_high;
    logic [63:0] m_result_low;
    logic        m_status;

    aes_block_cipher_modes_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action), .s_restart(s_restart),
        .s_valid_bytes(s_valid_bytes), .s_block_high(s_block_high), .s_block_low(s_block_low),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_high(m_result_high),
        .m_result_low(m_result_low), .m_status(m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mirror of the engine state.
    logic [63:0] key_reg [4];
    logic [1:0]  key_size_reg;
    logic [63:0] iv_hi_reg, iv_lo_reg;
    logic [31:0] sched [60];
    int          rounds;
    logic        sched_valid;
    logic [127:0] ctr_val, chain_val;

    block_item_t pending_blocks [$];
    cipher_out_t predicted_results [$];
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int errors = 0;
    int blocks_sent = 0;
    int results_seen = 0;
    int cycles = 0;

    function automatic logic [7:0] gmul(logic [7:0] a, int b);
        logic [7:0] p;
        p = 8'h00;
        while (b != 0) begin
            if (b & 1) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b >>= 1;
        end
        return p;
    endfunction

    function automatic logic [127:0] xor_key(logic [127:0] s, int r);
        return s ^ {sched[4 * r], sched[4 * r + 1], sched[4 * r + 2], sched[4 * r + 3]};
    endfunction

    function automatic logic [31:0] sbox_word(logic [31:0] t);
        return {aesbcm_pkg::SBOX[t[31:24]], aesbcm_pkg::SBOX[t[23:16]],
                aesbcm_pkg::SBOX[t[15:8]], aesbcm_pkg::SBOX[t[7:0]]};
    endfunction

    function automatic void expand_schedule();
        int nk;
        logic [31:0] t;
        logic [7:0] rc;
        nk = (key_size_reg == aesbcm_pkg::KSZ_128) ? 4 :
             (key_size_reg == aesbcm_pkg::KSZ_192) ? 6 : 8;
        rounds = nk + 6;
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            sched[i] = (i % 2) ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
        for (int i = nk; i < 4 * (rounds + 1); i++) begin
            t = sched[i - 1];
            if (i % nk == 0) begin
                t = {t[23:0], t[31:24]};
                t = sbox_word(t);
                t ^= {rc, 24'h0};
                rc = gmul(rc, 2);
            end else if (nk > 6 && i % nk == 4) begin
                t = sbox_word(t);
            end
            sched[i] = sched[i - nk] ^ t;
        end
        sched_valid = 1'b1;
    endfunction

    function automatic logic [127:0] aes_encrypt(logic [127:0] v);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        v = xor_key(v, 0);
        for (int r = 1; r <= rounds; r++) begin
            for (int j = 0; j < 16; j++) t[j] = aesbcm_pkg::SBOX[v[127 - 8 * j -: 8]];
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) s[4 * c + i] = t[4 * ((c + i) % 4) + i];
            if (r != rounds) begin
                for (int c = 0; c < 16; c += 4) begin
                    a0 = s[c]; a1 = s[c + 1]; a2 = s[c + 2]; a3 = s[c + 3];
                    s[c]     = gmul(a0, 2) ^ gmul(a1, 3) ^ a2 ^ a3;
                    s[c + 1] = a0 ^ gmul(a1, 2) ^ gmul(a2, 3) ^ a3;
                    s[c + 2] = a0 ^ a1 ^ gmul(a2, 2) ^ gmul(a3, 3);
                    s[c + 3] = gmul(a0, 3) ^ a1 ^ a2 ^ gmul(a3, 2);
                end
            end
            for (int j = 0; j < 16; j++) v[127 - 8 * j -: 8] = s[j];
            v = xor_key(v, r);
        end
        return v;
    endfunction

    function automatic logic [127:0] aes_decrypt(logic [127:0] v);
        logic [7:0] s [16];
        logic [7:0] a0, a1, a2, a3;
        v = xor_key(v, rounds);
        for (int r = rounds - 1; r >= 0; r--) begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    s[4 * ((c + i) % 4) + i] = aesbcm_pkg::RSBOX[v[127 - 8 * (4 * c + i) -: 8]];
            for (int j = 0; j < 16; j++) v[127 - 8 * j -: 8] = s[j];
            v = xor_key(v, r);
            if (r > 0) begin
                for (int j = 0; j < 16; j++) s[j] = v[127 - 8 * j -: 8];
                for (int c = 0; c < 16; c += 4) begin
                    a0 = s[c]; a1 = s[c + 1]; a2 = s[c + 2]; a3 = s[c + 3];
                    s[c]     = gmul(a0, 14) ^ gmul(a1, 11) ^ gmul(a2, 13) ^ gmul(a3, 9);
                    s[c + 1] = gmul(a0, 9) ^ gmul(a1, 14) ^ gmul(a2, 11) ^ gmul(a3, 13);
                    s[c + 2] = gmul(a0, 13) ^ gmul(a1, 9) ^ gmul(a2, 14) ^ gmul(a3, 11);
                    s[c + 3] = gmul(a0, 11) ^ gmul(a1, 13) ^ gmul(a2, 9) ^ gmul(a3, 14);
                end
                for (int j = 0; j < 16; j++) v[127 - 8 * j -: 8] = s[j];
            end
        end
        return v;
    endfunction

    function automatic cipher_out_t predict_block(block_item_t it);
        cipher_out_t res;
        logic [127:0] d;
        int n;
        if (!sched_valid) expand_schedule();
        if (it.restart) begin
            ctr_val = {iv_hi_reg, iv_lo_reg};
            chain_val = {iv_hi_reg, iv_lo_reg};
        end
        n = (it.vbytes > 16) ? 16 : it.vbytes;
        d = {it.hi, it.lo};
        res.status = 1'b0;
        case (it.action)
            aesbcm_pkg::ACT_CTR: begin
                if (n > 0) begin
                    d ^= aes_encrypt(ctr_val);
                    ctr_val = ctr_val + 128'd1;
                end
            end
            aesbcm_pkg::ACT_CBC_ENC, aesbcm_pkg::ACT_CBC_DEC: begin
                if (n < 16) begin
                    res.status = 1'b1;
                    n = 0;
                end else if (it.action == aesbcm_pkg::ACT_CBC_ENC) begin
                    d = aes_encrypt(d ^ chain_val);
                    chain_val = d;
                end else begin
                    d = aes_decrypt(d) ^ chain_val;
                    chain_val = {it.hi, it.lo};
                end
            end
            aesbcm_pkg::ACT_RAW_ENC: d = aes_encrypt(d);
            aesbcm_pkg::ACT_RAW_DEC: d = aes_decrypt(d);
            default: n = 0;
        endcase
        for (int j = n; j < 16; j++) d[127 - 8 * j -: 8] = 8'h00;
        res.hi = d[127:64];
        res.lo = d[63:0];
        return res;
    endfunction

    // Driver: one nonblocking assignment per signal and edge.
    always @(posedge aclk) begin
        block_item_t it;
        logic fire;
        fire = s_valid && s_ready;
        if (fire) begin
            predicted_results.push_back(predict_block('{s_action, s_restart, s_valid_bytes,
                                                       s_block_high, s_block_low}));
            blocks_sent++;
        end
        if (aresetn && (!s_valid || fire) && pending_blocks.size() > 0 &&
            $urandom_range(99) >= sender_idle_pct) begin
            it = pending_blocks.pop_front();
            s_valid <= 1'b1;
            s_action <= it.action;
            s_restart <= it.restart;
            s_valid_bytes <= it.vbytes;
            s_block_high <= it.hi;
            s_block_low <= it.lo;
        end else if (fire) begin
            s_valid <= 1'b0;
        end
    end

    // Monitor and checker.
    always @(posedge aclk) begin
        cipher_out_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (predicted_results.size() == 0) begin
                $error("Result with no block outstanding: %h %h %b",
                       m_result_high, m_result_low, m_status);
                errors++;
            end else begin
                exp_res = predicted_results.pop_front();
                if (m_result_high !== exp_res.hi) begin
                    $error("result_high expected %h actual %h", exp_res.hi, m_result_high);
                    errors++;
                end
                if (m_result_low !== exp_res.lo) begin
                    $error("result_low expected %h actual %h", exp_res.lo, m_result_low);
                    errors++;
                end
                if (m_status !== exp_res.status) begin
                    $error("status expected %b actual %b", exp_res.status, m_status);
                    errors++;
                end
            end
        end
        m_ready <= aresetn && ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        if (idx <= aesbcm_pkg::REG_KEY3) begin
            key_reg[idx[1:0]] = val;
            sched_valid = 1'b0;
        end else if (idx == aesbcm_pkg::REG_KEYSIZE) begin
            key_size_reg = val[1:0];
            sched_valid = 1'b0;
        end else if (idx == aesbcm_pkg::REG_IV_HIGH) begin
            iv_hi_reg = val;
        end else begin
            iv_lo_reg = val;
        end
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (pending_blocks.size() > 0 || s_valid || predicted_results.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void queue_block(logic [2:0] a, logic r, logic [4:0] n,
                                        logic [63:0] h, logic [63:0] l);
        block_item_t it;
        it = '{a, r, n, h, l};
        pending_blocks.push_back(it);
    endfunction

    function automatic void queue_random(int count);
        logic [2:0] a;
        logic [4:0] n;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 85) begin
                a = 3'($urandom_range(aesbcm_pkg::ACT_RAW_DEC, aesbcm_pkg::ACT_CTR));
                n = ($urandom_range(3) != 0) ? 5'd16 : 5'($urandom_range(16, 1));
                queue_block(a, $urandom_range(99) < 5, n, rand64(), rand64());
            end else begin
                queue_block(3'($urandom), 1'($urandom), 5'($urandom), rand64(), rand64());
            end
        end
    endfunction

    initial begin
        for (int i = 0; i < 4; i++) key_reg[i] = '0;
        key_size_reg = aesbcm_pkg::KSZ_128;
        iv_hi_reg = '0;
        iv_lo_reg = '0;
        rounds = 10;
        sched_valid = 1'b0;
        ctr_val = '0;
        chain_val = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed blocks with the reset configuration.
        queue_block(aesbcm_pkg::ACT_CTR, 1'b0, 5'd16, '0, '0);
        queue_block(aesbcm_pkg::ACT_CTR, 1'b1, 5'd16, '1, '1);
        queue_block(aesbcm_pkg::ACT_CTR, 1'b0, 5'd1, '1, '1);
        queue_block(aesbcm_pkg::ACT_CTR, 1'b0, 5'd0, '1, '1);
        queue_block(aesbcm_pkg::ACT_CTR, 1'b0, 5'd31, rand64(), rand64());
        queue_block(aesbcm_pkg::ACT_CBC_ENC, 1'b1, 5'd16, '0, '0);
        queue_block(aesbcm_pkg::ACT_CBC_ENC, 1'b0, 5'd15, '1, '1);
        queue_block(aesbcm_pkg::ACT_CBC_ENC, 1'b0, 5'd17, rand64(), rand64());
        queue_block(aesbcm_pkg::ACT_CBC_DEC, 1'b0, 5'd16, '1, '1);
        queue_block(aesbcm_pkg::ACT_CBC_DEC, 1'b1, 5'd0, '1, '1);
        queue_block(aesbcm_pkg::ACT_CBC_DEC, 1'b0, 5'd16, rand64(), rand64());
        queue_block(aesbcm_pkg::ACT_RAW_ENC, 1'b0, 5'd16, '0, '0);
        queue_block(aesbcm_pkg::ACT_RAW_ENC, 1'b0, 5'd0, '1, '1);
        queue_block(aesbcm_pkg::ACT_RAW_ENC, 1'b0, 5'd9, '1, '1);
        queue_block(aesbcm_pkg::ACT_RAW_DEC, 1'b0, 5'd16, '1, '1);
        queue_block(aesbcm_pkg::ACT_RAW_DEC, 1'b0, 5'd8, rand64(), rand64());
        queue_block(3'd5, 1'b0, 5'd16, '1, '1);
        queue_block(3'd6, 1'b1, 5'd31, '1, '1);
        queue_block(3'd7, 1'b0, 5'd16, rand64(), rand64());
        queue_block(aesbcm_pkg::ACT_CTR, 1'b0, 5'd16, rand64(), rand64());
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 3) begin
                sender_idle_pct = 9;
                receiver_idle_pct = 64;
            end else if (ph < 6) begin
                sender_idle_pct = 64;
                receiver_idle_pct = 9;
            end else begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            case (ph)
                0: begin
                    for (int k = 0; k < 4; k++) write_reg(3'(k), '1);
                    write_reg(aesbcm_pkg::REG_KEYSIZE, 64'(aesbcm_pkg::KSZ_128));
                    write_reg(aesbcm_pkg::REG_IV_HIGH, '1);
                    write_reg(aesbcm_pkg::REG_IV_LOW, 64'hffff_ffff_ffff_fffd);
                end
                1: begin
                    for (int k = 0; k < 4; k++) write_reg(3'(k), rand64());
                    write_reg(aesbcm_pkg::REG_KEYSIZE, 64'(aesbcm_pkg::KSZ_192));
                    write_reg(aesbcm_pkg::REG_IV_HIGH, rand64());
                    write_reg(aesbcm_pkg::REG_IV_LOW, 64'hffff_ffff_ffff_fffe);
                end
                2: begin
                    write_reg(aesbcm_pkg::REG_KEYSIZE, 64'(aesbcm_pkg::KSZ_256));
                    write_reg(aesbcm_pkg::REG_IV_LOW, rand64());
                end
                3: begin
                    write_reg(aesbcm_pkg::REG_KEY3, rand64());
                    write_reg(aesbcm_pkg::REG_KEYSIZE, 64'(aesbcm_pkg::KSZ_UNUSED));
                end
                4: begin
                    write_reg(aesbcm_pkg::REG_KEY0, '0);
                    write_reg(aesbcm_pkg::REG_KEY1, '0);
                    write_reg(aesbcm_pkg::REG_KEYSIZE, 64'(aesbcm_pkg::KSZ_128));
                    write_reg(aesbcm_pkg::REG_IV_HIGH, '0);
                    write_reg(aesbcm_pkg::REG_IV_LOW, '0);
                end
                5: begin
                    write_reg(aesbcm_pkg::REG_KEY2, '1);
                    write_reg(aesbcm_pkg::REG_KEYSIZE, 64'(aesbcm_pkg::KSZ_192));
                end
                default: begin
                    for (int k = 0; k < 4; k++) write_reg(3'(k), rand64());
                    write_reg(aesbcm_pkg::REG_KEYSIZE, 64'($urandom_range(3)));
                    write_reg(aesbcm_pkg::REG_IV_HIGH, rand64());
                    write_reg(aesbcm_pkg::REG_IV_LOW, rand64());
                end
            endcase
            end_writes();
            queue_block(aesbcm_pkg::ACT_CTR, 1'b1, 5'd16, rand64(), rand64());
            queue_block(aesbcm_pkg::ACT_CBC_ENC, 1'b1, 5'd16, rand64(), rand64());
            queue_random(240);
            drain();
        end

        $display("Sent %0d blocks over 9 key and IV settings, all actions and byte counts,",
                 blocks_sent);
        $display("and checked %0d results under varied source and sink stalls.", results_seen);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
rtl/core/aesbcm_pkg.sv
rtl/core/aesbcm_ctrl.sv
rtl/core/aesbcm_dp.sv
rtl/core/aes_block_cipher_modes_top.sv
tb/tb_aes_block_cipher_modes_top.sv
